/* hdl/sspp_pkg.sv */
package sspp_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] MIN_LENGTH    = 8'd2;
    localparam logic [7:0] RST_EXPECT_ID = 8'd1;
    localparam logic [7:0] RST_ERR_MASK  = 8'd35;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    // register index as seen on paddr[2]
    localparam logic REG_EXPECT_ID = 1'b0;
    localparam logic REG_ERR_MASK  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_CSUM  = 3'd1,
        STATUS_WRONG_ID  = 3'd2,
        STATUS_SHORT_LEN = 3'd3,
        STATUS_ABORTED   = 3'd4,
        STATUS_DEV_ERR   = 3'd5
    } t_status;

    typedef enum logic {
        PARSE_HUNT,
        PARSE_BODY
    } t_parse_state;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       byte_valid;
        logic       is_last;
        t_status    status;
    } t_result;

endpackage

/* hdl/sspp_front.sv */
module sspp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_expected_id,
    input  logic [7:0]        i_allowed_error_mask,
    input  logic              i_queue_full,
    output logic              o_push,
    output sspp_pkg::t_result o_result
);

    sspp_pkg::t_parse_state r_state, n_state;
    logic [7:0] r_win0, r_win1, r_win2;
    logic [7:0] n_win0, n_win1, n_win2;
    logic [1:0] r_win_count, n_win_count;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_dev_err, n_dev_err;
    logic       r_first, n_first;

    logic accept;
    assign accept = i_valid && !i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sspp_pkg::PARSE_HUNT;
            r_win0       <= '0;
            r_win1       <= '0;
            r_win2       <= '0;
            r_win_count  <= '0;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_dev_err    <= '0;
            r_first      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_win0       <= n_win0;
            r_win1       <= n_win1;
            r_win2       <= n_win2;
            r_win_count  <= n_win_count;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_dev_err    <= n_dev_err;
            r_first      <= n_first;
        end
    end

    always_comb begin
        logic [7:0] csum_expect;
        n_state      = r_state;
        n_win0       = r_win0;
        n_win1       = r_win1;
        n_win2       = r_win2;
        n_win_count  = r_win_count;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_dev_err    = r_dev_err;
        n_first      = r_first;
        o_push       = 1'b0;
        o_result     = '{body_byte: 8'd0, byte_valid: 1'b0, is_last: 1'b0,
                         status: sspp_pkg::STATUS_OK};
        csum_expect  = ~r_sum;

        if (accept) begin
            if (i_kind == sspp_pkg::KIND_ABORT || r_state == sspp_pkg::PARSE_BODY) begin
                // every path from here (except a body byte) returns to hunt
                n_state      = sspp_pkg::PARSE_HUNT;
                n_win0       = '0;
                n_win1       = '0;
                n_win2       = '0;
                n_win_count  = '0;
                n_bytes_left = '0;
                n_sum        = '0;
                n_dev_err    = '0;
                n_first      = 1'b0;
            end

            if (i_kind == sspp_pkg::KIND_ABORT) begin
                if (r_state == sspp_pkg::PARSE_BODY) begin
                    o_push           = 1'b1;
                    o_result.is_last = 1'b1;
                    o_result.status  = sspp_pkg::STATUS_ABORTED;
                end
            end else begin
                case (r_state)
                    sspp_pkg::PARSE_BODY: begin
                        if (r_bytes_left > 8'd1) begin
                            // body byte: stay in frame
                            n_state      = sspp_pkg::PARSE_BODY;
                            n_sum        = r_sum + i_rx_byte;
                            n_bytes_left = r_bytes_left - 8'd1;
                            n_dev_err    = r_first ? i_rx_byte : r_dev_err;
                            n_first      = 1'b0;
                            o_push              = 1'b1;
                            o_result.body_byte  = i_rx_byte;
                            o_result.byte_valid = 1'b1;
                        end else begin
                            // checksum byte
                            o_push           = 1'b1;
                            o_result.is_last = 1'b1;
                            if (i_rx_byte != csum_expect) begin
                                o_result.status = sspp_pkg::STATUS_BAD_CSUM;
                            end else if ((r_dev_err & ~i_allowed_error_mask) != 8'd0) begin
                                o_result.status = sspp_pkg::STATUS_DEV_ERR;
                            end else begin
                                o_result.status = sspp_pkg::STATUS_OK;
                            end
                        end
                    end
                    sspp_pkg::PARSE_HUNT: begin
                        if (r_win_count != 2'd3) begin
                            case (r_win_count)
                                2'd0:    n_win0 = i_rx_byte;
                                2'd1:    n_win1 = i_rx_byte;
                                default: n_win2 = i_rx_byte;
                            endcase
                            n_win_count = r_win_count + 2'd1;
                        end else if (r_win0 == sspp_pkg::SYNC_BYTE &&
                                     r_win1 == sspp_pkg::SYNC_BYTE) begin
                            // header complete: win2 is id, this byte is length
                            n_win0      = '0;
                            n_win1      = '0;
                            n_win2      = '0;
                            n_win_count = '0;
                            if (r_win2 != i_expected_id) begin
                                o_push           = 1'b1;
                                o_result.is_last = 1'b1;
                                o_result.status  = sspp_pkg::STATUS_WRONG_ID;
                            end else if (i_rx_byte < sspp_pkg::MIN_LENGTH) begin
                                o_push           = 1'b1;
                                o_result.is_last = 1'b1;
                                o_result.status  = sspp_pkg::STATUS_SHORT_LEN;
                            end else begin
                                n_state      = sspp_pkg::PARSE_BODY;
                                n_bytes_left = i_rx_byte;
                                n_sum        = r_win2 + i_rx_byte;
                                n_dev_err    = '0;
                                n_first      = 1'b1;
                            end
                        end else begin
                            n_win0 = r_win1;
                            n_win1 = r_win2;
                            n_win2 = i_rx_byte;
                        end
                    end
                    default: begin
                        n_state = sspp_pkg::PARSE_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

/* hdl/sspp_fifo.sv */
module sspp_fifo #(
    parameter int unsigned DEPTH = sspp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sspp_pkg::t_result i_data,
    input  logic              i_pop,
    output sspp_pkg::t_result o_data,
    output logic              o_empty,
    output logic              o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sspp_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/sspp_back.sv */
module sspp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sspp_pkg::t_result i_data,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output sspp_pkg::t_result o_result
);

    logic              r_valid;
    sspp_pkg::t_result r_result;
    logic              load;

    // output register takes a new beat when empty or being drained
    assign load    = !r_valid || !i_stall;
    assign o_pop   = load && !i_empty;
    assign o_valid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

endmodule

/* hdl/servo_status_packet_parser_top.sv */
// Servo status packet parser. Received serial bytes (kind 0) or abort
// markers (kind 1) come in one beat at a time; the block hunts for the
// 0xFF 0xFF sync pair, checks the id against expected_id and the length
// against a minimum of 2, then passes each body byte out as a beat (device
// error code first) and closes the frame with one beat carrying the status:
// ok, bad checksum, device error (error bits outside allowed_error_mask),
// wrong id, short length or aborted. Sync hunting and a good header make no
// output beat. Throughput is one input beat per clock while o_stall is low:
// the parser front end updates its registered state from each accepted beat
// and writes any result into a QUEUE_DEPTH-entry queue, which an output
// register drains. o_stall rises only when that queue is full. With nothing
// waiting ahead of it, a result is written into the queue when its byte is
// accepted and is then loaded into the output register. Registers sit at
// byte address 0 (expected_id, reset 1) and 4 (allowed_error_mask, reset
// 35); write them only while no frame is in flight and the output is empty.
module servo_status_packet_parser_top #(
    parameter int unsigned QUEUE_DEPTH = sspp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_body_byte,
    output logic        o_byte_valid,
    output logic        o_is_last,
    output logic [2:0]  o_status,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0] r_expected_id;
    logic [7:0] r_allowed_error_mask;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id        <= sspp_pkg::RST_EXPECT_ID;
            r_allowed_error_mask <= sspp_pkg::RST_ERR_MASK;
        end else if (cfg_write) begin
            case (paddr[2])
                sspp_pkg::REG_EXPECT_ID: r_expected_id        <= pwdata[7:0];
                sspp_pkg::REG_ERR_MASK:  r_allowed_error_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sspp_pkg::REG_EXPECT_ID: prdata = {24'd0, r_expected_id};
            sspp_pkg::REG_ERR_MASK:  prdata = {24'd0, r_allowed_error_mask};
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front end: framing state; while the queue has room, one byte per clock
    // ---------------------------------------------------------------
    logic              q_push, q_pop, q_empty, q_full;
    sspp_pkg::t_result q_wr_data, q_rd_data, out_result;

    assign o_stall = q_full;

    sspp_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .i_kind               (i_kind),
        .i_rx_byte            (i_rx_byte),
        .i_expected_id        (r_expected_id),
        .i_allowed_error_mask (r_allowed_error_mask),
        .i_queue_full         (q_full),
        .o_push               (q_push),
        .o_result             (q_wr_data)
    );

    // ---------------------------------------------------------------
    // Result queue between front end and output stage
    // ---------------------------------------------------------------
    sspp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // ---------------------------------------------------------------
    // Back end: output register
    // ---------------------------------------------------------------
    sspp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (q_rd_data),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_body_byte  = out_result.body_byte;
    assign o_byte_valid = out_result.byte_valid;
    assign o_is_last    = out_result.is_last;
    assign o_status     = out_result.status;

`ifndef SYNTHESIS
    // a body byte beat never ends a frame and always reports ok
    a_body_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid |-> !o_is_last && (o_status == sspp_pkg::STATUS_OK))
        else $error("body beat flagged last or with error status");

    // every beat without a body byte closes a frame and carries a zero byte
    a_nonbody_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_is_last && (o_body_byte == 8'd0))
        else $error("non-body beat not closing a frame");

    // failure status only on the closing beat
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != sspp_pkg::STATUS_OK) |-> o_is_last && !o_byte_valid)
        else $error("error status on a mid-frame beat");
`endif

endmodule
